// ===== rtl/core/quaternion_alu_macros.svh =====
// quaternion_alu_macros.svh
// assertion macros for the quaternion alu rtl, no dependencies
// NO_ASSERTIONS turns every assertion into an empty line
`ifndef QUATERNION_ALU_MACROS_SVH
`define QUATERNION_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QALU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QALU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QALU_ASSERT(label, clk, rst, prop, msg)
`define QALU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/qalu_pkg.sv =====
// qalu_pkg.sv
// shared types and constants of the quaternion alu
// no dependencies
package qalu_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int SQRT_STEPS        = 32;

  typedef logic signed [31:0] comp_t;
  typedef comp_t quat_t [4];

  typedef enum logic [1:0] {
    OP_HAMILTON  = 2'd0,
    OP_ROTATE    = 2'd1,
    OP_NORMALIZE = 2'd2
  } op_t;

endpackage

// ===== rtl/core/quaternion_alu.sv =====
// quaternion_alu.sv
// quaternion alu top level: hamilton product, vector rotate, normalize
// in signed fixed point; uses qalu_pkg, qalu_norm, quaternion_alu_macros.svh
//
//  channel   handshake                  payload
//  item      item_valid / item_stall    operation, a_w..a_z, b_w..b_z
//  result    result_valid / result_stall r_w..r_z, saturated, zero_magnitude
//
// one item per cycle while no stalled result holds the pipeline;
// the normalize path, with its 32-stage square root and the
// FRAC_BITS+1 stage divider lanes, is the longest path
// product and rotate results wait in a delay line to match it
// rst clears only the stage valid bits
// a stalled result freezes every stage; item_stall follows it directly
`include "quaternion_alu_macros.svh"

module quaternion_alu #(
  parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  a_w,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic signed [31:0]  b_w,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  r_w,
  output logic signed [31:0]  r_x,
  output logic signed [31:0]  r_y,
  output logic signed [31:0]  r_z,
  output logic                saturated,
  output logic                zero_magnitude
);

  localparam int RW       = 64 - FRAC_BITS;
  localparam int HW       = RW + 2;
  localparam int DW       = RW + 1;
  localparam int SW       = RW + 3;
  localparam int NORM_LAT = qalu_pkg::SQRT_STEPS + FRAC_BITS + 2;
  localparam int DEPTH    = NORM_LAT + 3;
  localparam int DLY      = NORM_LAT - 7;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = SW'(32'sh7fffffff);
  localparam logic signed [SW-1:0] MINV = SW'(32'sh80000000);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef struct {
    qalu_pkg::op_t   op;
    qalu_pkg::quat_t r;
    logic            sat;
  } front_t;

  function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
    logic [32:0] res;
    if (v > MAXV) begin
      res = {1'b1, 32'h7fffffff};
    end else if (v < MINV) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  logic             en;
  logic [DEPTH:1]   vld;

  assign en         = !(vld[DEPTH] && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-1:1], item_valid};
    end
  end

  // stage 1: sixteen products, b swapped for a on normalize to get squares
  qalu_pkg::quat_t   a_in, b_in, bm;
  qalu_pkg::op_t     op_in;
  logic signed [63:0] p_next [16];

  assign op_in = qalu_pkg::op_t'(operation);
  assign a_in  = '{a_w, a_x, a_y, a_z};
  assign b_in  = '{b_w, b_x, b_y, b_z};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bm[j] = (op_in == qalu_pkg::OP_NORMALIZE) ? a_in[j] : b_in[j];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_next[i*4+j] = a_in[i] * bm[j];
      end
    end
  end

  qalu_pkg::op_t      op1, op2, op3, op4, op5, op6, op7, op8;
  qalu_pkg::quat_t    a1, a2, a3, a4;
  qalu_pkg::comp_t    vec1 [3], vec2 [3], vec3 [3], vec4 [3], vec5 [3], vec6 [3], vec7 [3];
  logic signed [63:0] p1 [16];
  logic signed [RW-1:0] r2 [16];
  logic [63:0]        sq2;
  logic signed [HW-1:0] h3 [4];
  logic signed [DW-1:0] d3 [3];
  qalu_pkg::quat_t    ham4, ham5, ham6, ham7, ham8;
  logic               hsat4, hsat5, hsat6, hsat7, hsat8;
  qalu_pkg::comp_t    c1_4 [3];
  logic               csat4, csat5, csat6, csat7, csat8;
  logic signed [63:0] p5 [9];
  logic signed [RW-1:0] r6 [9];
  qalu_pkg::comp_t    c2_7 [3];
  logic signed [RW-1:0] rs7 [3];
  logic signed [SW-1:0] t8 [3];
  front_t             f9;

  // stage 2: round products, sum of squares clipped at all ones
  logic signed [RW-1:0] r2_next [16];
  logic [65:0]          sq_sum;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      r2_next[k] = RW'((p1[k] + HALF) >>> FRAC_BITS);
    end
    sq_sum = {2'b00, p1[0]} + {2'b00, p1[5]} + {2'b00, p1[10]} + {2'b00, p1[15]};
  end

  // stage 3: product sums and first cross product differences
  logic signed [HW-1:0] h3_next [4];
  logic signed [DW-1:0] d3_next [3];

  always_comb begin
    h3_next[0] = HW'(r2[0]) - HW'(r2[5]) - HW'(r2[10]) - HW'(r2[15]);
    h3_next[1] = HW'(r2[1]) + HW'(r2[4]) + HW'(r2[11]) - HW'(r2[14]);
    h3_next[2] = HW'(r2[2]) - HW'(r2[7]) + HW'(r2[8]) + HW'(r2[13]);
    h3_next[3] = HW'(r2[3]) + HW'(r2[6]) - HW'(r2[9]) + HW'(r2[12]);
    d3_next[0] = DW'(r2[11]) - DW'(r2[14]);
    d3_next[1] = DW'(r2[13]) - DW'(r2[7]);
    d3_next[2] = DW'(r2[6]) - DW'(r2[9]);
  end

  // stage 4: saturate
  qalu_pkg::quat_t ham4_next;
  qalu_pkg::comp_t c1_next [3];
  logic            hsat_next, csat_next;
  logic [32:0]     s4;

  always_comb begin
    hsat_next = 1'b0;
    csat_next = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s4 = sat32(SW'(h3[i]));
      ham4_next[i] = s4[31:0];
      hsat_next    = hsat_next | s4[32];
    end
    for (int k = 0; k < 3; k++) begin
      s4 = sat32(SW'(d3[k]));
      c1_next[k] = s4[31:0];
      csat_next  = csat_next | s4[32];
    end
  end

  // stage 5: u x c1 and s*c1 products
  logic signed [63:0] p5_next [9];

  always_comb begin
    p5_next[0] = a4[2] * c1_4[2];
    p5_next[1] = a4[3] * c1_4[1];
    p5_next[2] = a4[3] * c1_4[0];
    p5_next[3] = a4[1] * c1_4[2];
    p5_next[4] = a4[1] * c1_4[1];
    p5_next[5] = a4[2] * c1_4[0];
    for (int k = 0; k < 3; k++) begin
      p5_next[6+k] = a4[0] * c1_4[k];
    end
  end

  // stage 6: round
  logic signed [RW-1:0] r6_next [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      r6_next[k] = RW'((p5[k] + HALF) >>> FRAC_BITS);
    end
  end

  // stage 7: second cross product, saturated
  qalu_pkg::comp_t c2_next [3];
  logic            c2sat_next;
  logic [32:0]     s7;

  always_comb begin
    c2sat_next = csat6;
    for (int k = 0; k < 3; k++) begin
      s7 = sat32(SW'(DW'(r6[2*k]) - DW'(r6[2*k+1])));
      c2_next[k] = s7[31:0];
      c2sat_next = c2sat_next | s7[32];
    end
  end

  // stage 8: v + 2(s*c1 + c2), exact
  logic signed [SW-1:0] t8_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t8_next[k] = SW'(vec7[k]) + ((SW'(rs7[k]) + SW'(c2_7[k])) <<< 1);
    end
  end

  // stage 9: saturate rotate result, pick the front result
  front_t      f9_next;
  logic [32:0] s9;

  always_comb begin
    f9_next.op  = op8;
    f9_next.r   = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
    f9_next.sat = 1'b0;
    s9          = '0;
    unique case (op8)
      qalu_pkg::OP_HAMILTON: begin
        f9_next.r   = ham8;
        f9_next.sat = hsat8;
      end
      qalu_pkg::OP_ROTATE: begin
        f9_next.sat = csat8;
        for (int k = 0; k < 3; k++) begin
          s9 = sat32(t8[k]);
          f9_next.r[k+1] = s9[31:0];
          f9_next.sat    = f9_next.sat | s9[32];
        end
      end
      default: begin
        f9_next.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op_in;
      a1   <= a_in;
      vec1 <= '{b_x, b_y, b_z};
      p1   <= p_next;

      op2  <= op1;
      a2   <= a1;
      vec2 <= vec1;
      r2   <= r2_next;
      sq2  <= (sq_sum[65:64] != 2'b00) ? '1 : sq_sum[63:0];

      op3  <= op2;
      a3   <= a2;
      vec3 <= vec2;
      h3   <= h3_next;
      d3   <= d3_next;

      op4   <= op3;
      a4    <= a3;
      vec4  <= vec3;
      ham4  <= ham4_next;
      hsat4 <= hsat_next;
      c1_4  <= c1_next;
      csat4 <= csat_next;

      op5   <= op4;
      vec5  <= vec4;
      ham5  <= ham4;
      hsat5 <= hsat4;
      csat5 <= csat4;
      p5    <= p5_next;

      op6   <= op5;
      vec6  <= vec5;
      ham6  <= ham5;
      hsat6 <= hsat5;
      csat6 <= csat5;
      r6    <= r6_next;

      op7   <= op6;
      vec7  <= vec6;
      ham7  <= ham6;
      hsat7 <= hsat6;
      csat7 <= c2sat_next;
      c2_7  <= c2_next;
      rs7   <= '{r6[6], r6[7], r6[8]};

      op8   <= op7;
      ham8  <= ham7;
      hsat8 <= hsat7;
      csat8 <= csat7;
      t8    <= t8_next;

      f9    <= f9_next;
    end
  end

  // front results wait for the normalize path
  front_t fd [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      fd[0] <= f9;
      for (int k = 1; k < DLY; k++) begin
        fd[k] <= fd[k-1];
      end
    end
  end

  qalu_pkg::quat_t nq;
  logic            nz;

  qalu_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk  (clk),
    .en   (en),
    .sq   (sq2),
    .a    (a2),
    .nq   (nq),
    .zero (nz)
  );

  qalu_pkg::quat_t res;
  qalu_pkg::op_t   res_op;
  logic            res_sat, res_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      res_op <= fd[DLY-1].op;
      if (fd[DLY-1].op == qalu_pkg::OP_NORMALIZE) begin
        res      <= nq;
        res_sat  <= 1'b0;
        res_zero <= nz;
      end else begin
        res      <= fd[DLY-1].r;
        res_sat  <= fd[DLY-1].sat;
        res_zero <= 1'b0;
      end
    end
  end

  assign result_valid   = vld[DEPTH];
  assign r_w            = res[0];
  assign r_x            = res[1];
  assign r_y            = res[2];
  assign r_z            = res[3];
  assign saturated      = res_sat;
  assign zero_magnitude = res_zero;

  `QALU_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !result_valid, "result valid after reset")
  `QALU_ASSERT(a_stall_backs_up, clk, rst, (result_valid && result_stall) |-> item_stall, "item taken while result held")
  `QALU_ASSERT(a_flags_apart, clk, rst, result_valid |-> !(saturated && zero_magnitude), "both flags set")
  `QALU_ASSERT(a_rotate_w_zero, clk, rst, (result_valid && res_op == qalu_pkg::OP_ROTATE) |-> (r_w == 32'sd0), "rotate w not zero")
  `QALU_ASSERT(a_norm_bound, clk, rst, (result_valid && res_op == qalu_pkg::OP_NORMALIZE && !zero_magnitude) |-> (r_x <= ONE && r_x >= -ONE), "normalized x out of range")

endmodule

// ===== rtl/core/qalu_norm.sv =====
// qalu_norm.sv
// normalize pipeline: restoring square root, one root bit per stage,
// then four divider lanes, one quotient bit per stage; uses qalu_pkg
module qalu_norm #(
  parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       sq,
  input  qalu_pkg::quat_t   a,
  output qalu_pkg::quat_t   nq,
  output logic              zero
);

  localparam int SQ = qalu_pkg::SQRT_STEPS;
  localparam int QW = FRAC_BITS + 1;
  localparam int DV = QW;
  localparam int NW = 32 + FRAC_BITS + 1;

  logic [63:0]     sx [SQ];
  logic [63:0]     sr [SQ];
  qalu_pkg::quat_t sa [SQ];
  logic            sz [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (2 * (SQ - 1 - k));
    logic [63:0]     xin, rin, x_next, r_next;
    logic [64:0]     t;
    qalu_pkg::quat_t ain;
    logic            zin;
    if (k == 0) begin : g_first
      assign xin = sq;
      assign rin = '0;
      assign ain = a;
      assign zin = (sq == 64'd0);
    end else begin : g_rest
      assign xin = sx[k-1];
      assign rin = sr[k-1];
      assign ain = sa[k-1];
      assign zin = sz[k-1];
    end
    always_comb begin
      t = {1'b0, rin} + {1'b0, BITV};
      if ({1'b0, xin} >= t) begin
        x_next = xin - t[63:0];
        r_next = (rin >> 1) + BITV;
      end else begin
        x_next = xin;
        r_next = rin >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sx[k] <= x_next;
        sr[k] <= r_next;
        sa[k] <= ain;
        sz[k] <= zin;
      end
    end
  end

  logic [NW-1:0]   dr [DV][4];
  logic [QW-1:0]   dq [DV][4];
  logic [31:0]     dm [DV];
  qalu_pkg::quat_t da [DV];
  logic            dz [DV];

  for (genvar j = 0; j < DV; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [NW-1:0]   rem_in [4];
    logic [QW-1:0]   q_in [4];
    logic [NW-1:0]   rem_next [4];
    logic [QW-1:0]   q_next [4];
    logic [31:0]     m_in;
    logic [NW-1:0]   dsub;
    qalu_pkg::quat_t ain;
    logic            zin;
    if (j == 0) begin : g_first
      logic [31:0] mag [4];
      assign m_in = sr[SQ-1][31:0];
      assign ain  = sa[SQ-1];
      assign zin  = sz[SQ-1];
      // numerator carries half the divisor for round half away from zero
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign mag[i]    = sa[SQ-1][i][31] ? (~sa[SQ-1][i] + 32'd1) : sa[SQ-1][i];
        assign rem_in[i] = (NW'(mag[i]) << FRAC_BITS) + NW'(m_in >> 1);
        assign q_in[i]   = '0;
      end
    end else begin : g_rest
      assign m_in = dm[j-1];
      assign ain  = da[j-1];
      assign zin  = dz[j-1];
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = dr[j-1][i];
        assign q_in[i]   = dq[j-1][i];
      end
    end
    assign dsub = NW'(m_in) << SH;
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        if (rem_in[i] >= dsub) begin
          rem_next[i] = rem_in[i] - dsub;
          q_next[i]   = {q_in[i][QW-2:0], 1'b1};
        end else begin
          rem_next[i] = rem_in[i];
          q_next[i]   = {q_in[i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr[j] <= rem_next;
        dq[j] <= q_next;
        dm[j] <= m_in;
        da[j] <= ain;
        dz[j] <= zin;
      end
    end
  end

  qalu_pkg::quat_t nq_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dz[DV-1]) begin
        nq_next[i] = da[DV-1][i];
      end else if (da[DV-1][i][31]) begin
        nq_next[i] = -$signed(32'(dq[DV-1][i]));
      end else begin
        nq_next[i] = $signed(32'(dq[DV-1][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq   <= nq_next;
      zero <= dz[DV-1];
    end
  end

endmodule
